>>> src/pwlp_pkg.sv
// Shared types and constants for the power weighted light picker.
// Used by pwlp_store, pwlp_alu and power_weighted_light_pick.
`default_nettype none
package pwlp_pkg;

  localparam int DEFAULT_MAX_LIGHTS = 64;
  localparam int W_W       = 32;
  localparam int FRAC_W    = 24;
  localparam int TOT_W     = 38;
  localparam int PROD_W    = FRAC_W + TOT_W;
  localparam int PROB_W    = FRAC_W + 1;
  localparam int IDX_OUT_W = 6;
  localparam int STEP_W    = 5;
  localparam logic [W_W-1:0] CULL_RESET = 32'd655;
  localparam logic [PROB_W-1:0] PROB_ONE = 25'd16777216;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_ADD    = 2'd1,
    OP_SAMPLE = 2'd2,
    OP_PMF    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ALU_NOP = 2'd0,
    ALU_MUL = 2'd1,
    ALU_ACC = 2'd2,
    ALU_DIV = 2'd3
  } alu_op_t;

  typedef struct packed {
    alu_op_t           op;
    logic [PROD_W-1:0] a;
    logic [PROD_W-1:0] b;
    logic [PROD_W-1:0] c;
    logic              mbit;
  } alu_req_t;

  typedef struct packed {
    logic [PROD_W-1:0] res;
    logic              flag;
  } alu_rsp_t;

endpackage
`default_nettype wire

>>> src/pwlp_store.sv
// Weight table memory: one write port, one registered read port.
// Depends on pwlp_pkg for the weight width.
`default_nettype none
module pwlp_store
  import pwlp_pkg::*;
#(
  parameter int MAX_LIGHTS = DEFAULT_MAX_LIGHTS,
  localparam int IW = $clog2(MAX_LIGHTS)
) (
  input  wire logic           clk,
  input  wire logic           we,
  input  wire logic [IW-1:0]  waddr,
  input  wire logic [W_W-1:0] wdata,
  input  wire logic [IW-1:0]  raddr,
  output logic      [W_W-1:0] rdata
);

  logic [W_W-1:0] mem [MAX_LIGHTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> src/pwlp_alu.sv
// Shared arithmetic unit: multiply step, saturating accumulate with compare,
// restoring divide step. Depends on pwlp_pkg for request and response types.
`default_nettype none
module pwlp_alu
  import pwlp_pkg::*;
(
  input  wire alu_req_t req,
  output alu_rsp_t      rsp
);

  logic [TOT_W:0]   acc_sum;
  logic [TOT_W-1:0] acc_sat;
  logic [TOT_W:0]   div_sh;
  logic             div_ge;

  always_comb begin
    acc_sum = {1'b0, req.a[TOT_W-1:0]} + {1'b0, req.b[TOT_W-1:0]};
    acc_sat = acc_sum[TOT_W] ? {TOT_W{1'b1}} : acc_sum[TOT_W-1:0];
    div_sh  = {req.a[TOT_W-1:0], 1'b0};
    div_ge  = (div_sh >= req.b[TOT_W:0]);
    rsp     = '0;
    case (req.op)
      ALU_MUL: begin
        rsp.res = {req.a[PROD_W-2:0], 1'b0} + (req.mbit ? req.b : '0);
      end
      ALU_ACC: begin
        rsp.res  = PROD_W'(acc_sat);
        rsp.flag = ({acc_sat, {FRAC_W{1'b0}}} >= req.c);
      end
      ALU_DIV: begin
        rsp.res  = PROD_W'(div_ge ? div_sh - req.b[TOT_W:0] : div_sh);
        rsp.flag = div_ge;
      end
      default: begin
        rsp = '0;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> src/power_weighted_light_pick.sv
// Top level of the power weighted light picker: sequencer, state and output register.
// Depends on pwlp_pkg, pwlp_store and pwlp_alu.
//
// Keeps up to MAX_LIGHTS unsigned 16.16 light weights and their saturating
// 38-bit total. in_tuser carries the operation (clear, add, sample, pmf);
// in_tdata carries weight and fraction. Each transfer gives exactly one result.
// One item is worked at a time and in_tready is high only while the sequencer
// is idle; a finished result waits in the output register without blocking
// the next transfer. Clear, add and a pmf that is 1.0 go straight to the output
// register. A pmf below 1.0 first runs the 24-step restoring divider. A sample
// on a non-empty table runs a 24-step shift-add of fraction times total, then
// a scan of the table memory, one entry per cycle up to the pick, then the divider
// unless the picked weight reaches the total. Multiply, accumulate and divide
// share one add/compare unit. cull_threshold is written with cfg_we/cfg_wdata.
`default_nettype none
module power_weighted_light_pick
  import pwlp_pkg::*;
#(
  parameter int MAX_LIGHTS = DEFAULT_MAX_LIGHTS
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [55:0] in_tdata,   // weight[31:0], fraction[55:32]
  input  wire logic [1:0]  in_tuser,   // operation[1:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [71:0] out_tdata,  // found[0], accepted[1], chosen_index[7:2],
                                       // chosen_weight[39:8], probability[64:40]
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_wdata
);

  localparam int IW = $clog2(MAX_LIGHTS);
  localparam int CW = $clog2(MAX_LIGHTS + 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_SCAN = 5'b00100,
    S_DIV  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t            state_r, state_nxt;
  logic [W_W-1:0]    cull_r;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [TOT_W-1:0]  total_r, total_nxt;
  logic [PROD_W-1:0] acc_r, acc_nxt;
  logic [FRAC_W-1:0] frac_r, frac_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [TOT_W-1:0]  run_r, run_nxt;
  logic [CW-1:0]     issue_r, issue_nxt;
  logic [IW-1:0]     pidx_r, pidx_nxt;
  logic              dval_r, dval_nxt;
  logic [TOT_W-1:0]  rem_r, rem_nxt;
  logic              found_r, found_nxt;
  logic              accd_r, accd_nxt;
  logic [IW-1:0]     cidx_r, cidx_nxt;
  logic [W_W-1:0]    cw_r, cw_nxt;
  logic [PROB_W-1:0] prob_r, prob_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [71:0]       out_data_r, out_data_nxt;

  op_t               in_op;
  logic [W_W-1:0]    in_weight;
  logic [FRAC_W-1:0] in_frac;
  logic              in_xfer;
  logic              out_load;
  logic              mem_we;
  logic [W_W-1:0]    rdata;
  logic [W_W-1:0]    pmf_w;
  logic              pmf_one;
  logic              scan_last;
  logic [IW+5:0]     cidx_ext;
  alu_req_t          alu_req;
  alu_rsp_t          alu_rsp;

  assign in_op     = op_t'(in_tuser);
  assign in_weight = in_tdata[31:0];
  assign in_frac   = in_tdata[55:32];
  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign out_load  = (state_r == S_OUT) && (!out_valid_r || out_tready);
  assign mem_we    = in_xfer && (in_op == OP_ADD) && (in_weight >= cull_r) &&
                     (cnt_r < CW'(MAX_LIGHTS));
  assign pmf_w     = (state_r == S_SCAN) ? rdata : in_weight;
  assign pmf_one   = (total_r == '0) || ({{(TOT_W-W_W){1'b0}}, pmf_w} >= total_r);
  assign scan_last = ((CW'(pidx_r) + CW'(1)) == cnt_r);
  assign cidx_ext  = {{6{1'b0}}, cidx_r};
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  pwlp_store #(.MAX_LIGHTS(MAX_LIGHTS)) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (cnt_r[IW-1:0]),
    .wdata (in_weight),
    .raddr (issue_r[IW-1:0]),
    .rdata (rdata)
  );

  pwlp_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  always_comb begin
    alu_req = '0;
    case (state_r)
      S_IDLE: begin
        alu_req.op = ALU_ACC;
        alu_req.a  = PROD_W'(total_r);
        alu_req.b  = PROD_W'(in_weight);
      end
      S_MUL: begin
        alu_req.op   = ALU_MUL;
        alu_req.a    = acc_r;
        alu_req.b    = PROD_W'(total_r);
        alu_req.mbit = frac_r[FRAC_W-1];
      end
      S_SCAN: begin
        alu_req.op = ALU_ACC;
        alu_req.a  = PROD_W'(run_r);
        alu_req.b  = PROD_W'(rdata);
        alu_req.c  = acc_r;
      end
      S_DIV: begin
        alu_req.op = ALU_DIV;
        alu_req.a  = PROD_W'(rem_r);
        alu_req.b  = PROD_W'(total_r);
      end
      default: begin
        alu_req = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    total_nxt = total_r;
    acc_nxt   = acc_r;
    frac_nxt  = frac_r;
    step_nxt  = step_r;
    run_nxt   = run_r;
    issue_nxt = issue_r;
    pidx_nxt  = pidx_r;
    dval_nxt  = 1'b0;
    rem_nxt   = rem_r;
    found_nxt = found_r;
    accd_nxt  = accd_r;
    cidx_nxt  = cidx_r;
    cw_nxt    = cw_r;
    prob_nxt  = prob_r;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          found_nxt = 1'b0;
          accd_nxt  = 1'b0;
          cidx_nxt  = '0;
          cw_nxt    = '0;
          prob_nxt  = '0;
          state_nxt = S_OUT;
          case (in_op)
            OP_CLEAR: begin
              cnt_nxt   = '0;
              total_nxt = '0;
            end
            OP_ADD: begin
              if (mem_we) begin
                cnt_nxt   = cnt_r + CW'(1);
                total_nxt = alu_rsp.res[TOT_W-1:0];
                accd_nxt  = 1'b1;
              end
            end
            OP_SAMPLE: begin
              if (cnt_r != '0) begin
                acc_nxt   = '0;
                frac_nxt  = in_frac;
                step_nxt  = '0;
                state_nxt = S_MUL;
              end
            end
            default: begin
              if (pmf_one) begin
                prob_nxt = PROB_ONE;
              end else begin
                rem_nxt   = {{(TOT_W-W_W){1'b0}}, in_weight};
                step_nxt  = '0;
                state_nxt = S_DIV;
              end
            end
          endcase
        end
      end
      S_MUL: begin
        acc_nxt  = alu_rsp.res;
        frac_nxt = {frac_r[FRAC_W-2:0], 1'b0};
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(FRAC_W - 1)) begin
          run_nxt   = '0;
          issue_nxt = '0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (issue_r < cnt_r) begin
          issue_nxt = issue_r + CW'(1);
          pidx_nxt  = issue_r[IW-1:0];
          dval_nxt  = 1'b1;
        end
        if (dval_r) begin
          run_nxt = alu_rsp.res[TOT_W-1:0];
          if (alu_rsp.flag || scan_last) begin
            dval_nxt  = 1'b0;
            found_nxt = 1'b1;
            cidx_nxt  = pidx_r;
            cw_nxt    = rdata;
            if (pmf_one) begin
              prob_nxt  = PROB_ONE;
              state_nxt = S_OUT;
            end else begin
              rem_nxt   = {{(TOT_W-W_W){1'b0}}, rdata};
              step_nxt  = '0;
              state_nxt = S_DIV;
            end
          end
        end
      end
      S_DIV: begin
        rem_nxt  = alu_rsp.res[TOT_W-1:0];
        prob_nxt = {prob_r[PROB_W-2:0], alu_rsp.flag};
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(FRAC_W - 1)) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_tready;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {7'b0, prob_r, cw_r, cidx_ext[5:0], accd_r, found_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      total_r     <= '0;
      dval_r      <= 1'b0;
      out_valid_r <= 1'b0;
      cull_r      <= CULL_RESET;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      total_r     <= total_nxt;
      dval_r      <= dval_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        cull_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_r      <= acc_nxt;
    frac_r     <= frac_nxt;
    step_r     <= step_nxt;
    run_r      <= run_nxt;
    issue_r    <= issue_nxt;
    pidx_r     <= pidx_nxt;
    rem_r      <= rem_nxt;
    found_r    <= found_nxt;
    accd_r     <= accd_nxt;
    cidx_r     <= cidx_nxt;
    cw_r       <= cw_nxt;
    prob_r     <= prob_nxt;
    out_data_r <= out_data_nxt;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_LIGHTS))
    else $error("entry count above table depth");

  a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (issue_r <= cnt_r))
    else $error("scan issued past last entry");

  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data_r[0] && out_data_r[1]))
    else $error("found and accepted both set");

  a_prob_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r[64:40] <= PROB_ONE))
    else $error("probability above one");

  a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL) |-> (cnt_r != '0))
    else $error("sample started on empty table");

endmodule
`default_nettype wire
